FILE: rtl/abkt_pkg.sv
// Shared types and constants for the array binary search tree key table.
package abkt_pkg;

  localparam int unsigned TREE_SLOTS_DEF = 1023;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned CFG_W          = 10;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 10'd1023;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic hit;
    logic changed;
    logic out_of_room;
  } rsp_t;

  // one tree slot as held in the slot RAM
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } slot_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DEL_R,
    ST_DEL_RCHK,
    ST_DEL_LCHK,
    ST_WALK_CHK,
    ST_MOVE
  } state_t;

endpackage

FILE: rtl/abkt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module abkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/array_bst_key_table_unit.sv
// Top level of the array binary search tree key table.
// Flow: a taken word searches from the root down, reading one tree level at a time, where the
//   number of levels read on the search path is 1..10 at 1023 slots; done is registered. A
//   delete that hits then empties the last slot and, per slot moved up, reads down to the pick
//   (through the left child when the right child is empty) and copies the picked key up.
// Handshake: one word at a time; the next start is taken in the cycle that done is high.
// Reset: rst (synchronous) starts a clearing pass that writes every slot of the slot RAM
//   invalid, busy high throughout; slots_in_use returns to 1023. Results cannot be stalled.
module array_bst_key_table_unit
  import abkt_pkg::*;
#(
  parameter int unsigned TREE_SLOTS = TREE_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // command channel
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  // result channel
  output logic             done,
  output rsp_t             rsp,
  // slots_in_use register write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // slot index width, and a width that holds any child index or the usable limit
  localparam int unsigned IDX_W = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
  localparam int unsigned CW    = IDX_W + 2;
  localparam int unsigned CMP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TREE_SLOTS - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                  state, state_next;
  logic [CFG_W-1:0]        slots_in_use;
  logic [IDX_W-1:0]        clr_cnt, clr_cnt_next;
  logic [CMD_W-1:0]        op_cmd, op_cmd_next;
  logic signed [KEY_W-1:0] op_key, op_key_next;
  logic [IDX_W-1:0]        idx, idx_next;        // slot being searched / emptied
  logic [IDX_W-1:0]        probe, probe_next;    // slot read during the successor walk
  logic [IDX_W-1:0]        pick, pick_next;      // best successor/predecessor so far
  logic signed [KEY_W-1:0] pick_key, pick_key_next;
  logic                    walk_right, walk_right_next;
  logic                    done_next;
  rsp_t                    rsp_next;

  // ---------------------------------------------------------------------------
  // Slot RAM: valid bit and key per slot; read data is registered and returns in the next cycle
  // ---------------------------------------------------------------------------
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  slot_t            wr_slot, rd_slot;
  logic [$bits(slot_t)-1:0] rd_word;

  abkt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TREE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_slot = slot_t'(rd_word);

  // ---------------------------------------------------------------------------
  // Index arithmetic
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] lim;          // min(slots_in_use, TREE_SLOTS)
  logic [CMP_W-1:0] idx_w, idx_l, idx_r;
  logic [CMP_W-1:0] find_child;
  logic [CMP_W-1:0] walk_base, walk_cand;
  logic             walk_dir;
  logic             key_lt, key_eq;

  assign lim = (CMP_W'(slots_in_use) < CMP_W'(TREE_SLOTS)) ? CMP_W'(slots_in_use)
                                                           : CMP_W'(TREE_SLOTS);
  assign idx_w = CMP_W'(idx);
  assign idx_l = (idx_w << 1) + CMP_W'(1);
  assign idx_r = (idx_w << 1) + CMP_W'(2);

  assign key_lt = $signed(op_key) < $signed(rd_slot.key);
  assign key_eq = op_key == rd_slot.key;
  assign find_child = key_lt ? idx_l : idx_r;

  // The walk goes left from the right child (successor) or right from the left
  // child (predecessor); its base is the slot whose read is returning now.
  always_comb begin
    if (state == ST_DEL_RCHK) begin
      walk_base = idx_r;
      walk_dir  = 1'b0;
    end else if (state == ST_DEL_LCHK) begin
      walk_base = idx_l;
      walk_dir  = 1'b1;
    end else begin
      walk_base = CMP_W'(probe);
      walk_dir  = walk_right;
    end
    walk_cand = (walk_base << 1) + (walk_dir ? CMP_W'(2) : CMP_W'(1));
  end

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, RAM accesses, result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    op_cmd_next     = op_cmd;
    op_key_next     = op_key;
    idx_next        = idx;
    probe_next      = probe;
    pick_next       = pick;
    pick_key_next   = pick_key;
    walk_right_next = walk_right;
    done_next       = 1'b0;
    rsp_next        = rsp;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_slot.valid   = 1'b1;
    wr_slot.key     = op_key;
    rd_en           = 1'b0;
    rd_addr         = idx;

    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_cnt;
        wr_slot.valid = 1'b0;
        wr_slot.key   = '0;
        clr_cnt_next  = clr_cnt + IDX_W'(1);
        if (clr_cnt == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_cmd_next = req.cmd;
          op_key_next = req.key;
          idx_next    = '0;
          state_next  = ST_FIND_RD;
        end
      end

      // root access; unknown commands and an empty usable range finish here
      ST_FIND_RD: begin
        if (op_cmd != CMD_INSERT && op_cmd != CMD_SEARCH && op_cmd != CMD_DELETE) begin
          done_next            = 1'b1;
          rsp_next.hit         = 1'b0;
          rsp_next.changed     = 1'b0;
          rsp_next.out_of_room = 1'b0;
          state_next           = ST_IDLE;
        end else if (idx_w >= lim) begin
          done_next            = 1'b1;
          rsp_next.hit         = 1'b0;
          rsp_next.changed     = 1'b0;
          rsp_next.out_of_room = op_cmd == CMD_INSERT;
          state_next           = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx;
          state_next = ST_FIND_CHK;
        end
      end

      // one level per cycle: check returning slot, read the child right away
      ST_FIND_CHK: begin
        if (!rd_slot.valid) begin
          // empty slot: insert lands here, search/delete miss
          wr_en                = op_cmd == CMD_INSERT;
          done_next            = 1'b1;
          rsp_next.hit         = 1'b0;
          rsp_next.changed     = op_cmd == CMD_INSERT;
          rsp_next.out_of_room = 1'b0;
          state_next           = ST_IDLE;
        end else if (key_eq) begin
          rsp_next.hit         = 1'b1;
          rsp_next.changed     = op_cmd == CMD_DELETE;
          rsp_next.out_of_room = 1'b0;
          if (op_cmd == CMD_DELETE) begin
            state_next = ST_DEL_R;
          end else begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (find_child >= lim) begin
          done_next            = 1'b1;
          rsp_next.hit         = 1'b0;
          rsp_next.changed     = 1'b0;
          rsp_next.out_of_room = op_cmd == CMD_INSERT;
          state_next           = ST_IDLE;
        end else begin
          idx_next = find_child[IDX_W-1:0];
          rd_en    = 1'b1;
          rd_addr  = find_child[IDX_W-1:0];
        end
      end

      // idx holds a key to remove: probe right child, else left child
      ST_DEL_R: begin
        if (idx_r < lim) begin
          rd_en      = 1'b1;
          rd_addr    = idx_r[IDX_W-1:0];
          state_next = ST_DEL_RCHK;
        end else if (idx_l < lim) begin
          rd_en      = 1'b1;
          rd_addr    = idx_l[IDX_W-1:0];
          state_next = ST_DEL_LCHK;
        end else begin
          wr_en         = 1'b1;
          wr_slot.valid = 1'b0;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_DEL_RCHK: begin
        if (rd_slot.valid) begin
          pick_next       = idx_r[IDX_W-1:0];
          pick_key_next   = rd_slot.key;
          walk_right_next = 1'b0;
          if (walk_cand < lim) begin
            rd_en      = 1'b1;
            rd_addr    = walk_cand[IDX_W-1:0];
            probe_next = walk_cand[IDX_W-1:0];
            state_next = ST_WALK_CHK;
          end else begin
            state_next = ST_MOVE;
          end
        end else if (idx_l < lim) begin
          rd_en      = 1'b1;
          rd_addr    = idx_l[IDX_W-1:0];
          state_next = ST_DEL_LCHK;
        end else begin
          wr_en         = 1'b1;
          wr_slot.valid = 1'b0;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_DEL_LCHK: begin
        if (rd_slot.valid) begin
          pick_next       = idx_l[IDX_W-1:0];
          pick_key_next   = rd_slot.key;
          walk_right_next = 1'b1;
          if (walk_cand < lim) begin
            rd_en      = 1'b1;
            rd_addr    = walk_cand[IDX_W-1:0];
            probe_next = walk_cand[IDX_W-1:0];
            state_next = ST_WALK_CHK;
          end else begin
            state_next = ST_MOVE;
          end
        end else begin
          wr_en         = 1'b1;
          wr_slot.valid = 1'b0;
          done_next     = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      // follow the outer edge of the subtree while slots are present
      ST_WALK_CHK: begin
        if (rd_slot.valid) begin
          pick_next     = probe;
          pick_key_next = rd_slot.key;
          if (walk_cand < lim) begin
            rd_en      = 1'b1;
            rd_addr    = walk_cand[IDX_W-1:0];
            probe_next = walk_cand[IDX_W-1:0];
          end else begin
            state_next = ST_MOVE;
          end
        end else begin
          state_next = ST_MOVE;
        end
      end

      // copy the picked key up; the picked slot is removed next. Reads after
      // this only touch slots below pick, so the write never races a read.
      ST_MOVE: begin
        wr_en       = 1'b1;
        wr_slot.key = pick_key;
        idx_next    = pick;
        state_next  = ST_DEL_R;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      done         <= 1'b0;
      slots_in_use <= SLOTS_IN_USE_RST;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_cmd     <= op_cmd_next;
    op_key     <= op_key_next;
    idx        <= idx_next;
    probe      <= probe_next;
    pick       <= pick_next;
    pick_key   <= pick_key_next;
    walk_right <= walk_right_next;
    rsp        <= rsp_next;
  end

endmodule

FILE: rtl/abkt_checker.sv
// Port-level checks for the key table, bound to the top level.
module abkt_checker
  import abkt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // an accepted word is worked on; no result in the very next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not start work");

  // a result always frees the block in the same cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

  // a dropped insert neither hits nor changes anything
  a_room_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.out_of_room && (rsp.hit || rsp.changed)))
    else $error("out_of_room with hit or changed");

  // clearing pass runs after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind array_bst_key_table_unit abkt_checker u_abkt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

FILE: dv/array_bst_key_table_checker.sv
// Scoreboard for the key table: mirrors the tree and checks each result word.
module array_bst_key_table_checker
  import abkt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  req_t             req,
  input  logic             done,
  input  rsp_t             rsp,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               words_pending,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the slot RAM and the slots_in_use register
  bit                      mirror_used [TREE_SLOTS_DEF];
  logic signed [KEY_W-1:0] mirror_key  [TREE_SLOTS_DEF];
  logic [CFG_W-1:0]        mirror_limit = SLOTS_IN_USE_RST;
  rsp_t                    flags_due [$];
  int                      word_count = 0;

  initial fail_count = 0;
  initial words_pending = 0;

  function automatic int unsigned usable_slots();
    return (mirror_limit < TREE_SLOTS_DEF) ? mirror_limit : TREE_SLOTS_DEF;
  endfunction

  function automatic bit slot_taken(int unsigned idx);
    return idx < usable_slots() && mirror_used[idx];
  endfunction

  function automatic int unsigned step_down(int unsigned idx, logic signed [KEY_W-1:0] k);
    return (k < mirror_key[idx]) ? 2 * idx + 1 : 2 * idx + 2;
  endfunction

  // Apply one command to the mirror and return the flags it should produce.
  function automatic rsp_t apply_table_op(req_t w);
    int unsigned             idx;
    int unsigned             lim;
    int unsigned             pick;
    logic signed [KEY_W-1:0] k;
    rsp_t                    r;
    r   = '0;
    k   = w.key;
    lim = usable_slots();
    idx = 0;
    case (w.cmd)
      CMD_INSERT: begin
        while (1'b1) begin
          if (idx >= lim) begin
            r.out_of_room = 1'b1;
            break;
          end
          if (!mirror_used[idx]) begin
            mirror_used[idx] = 1'b1;
            mirror_key[idx]  = k;
            r.changed        = 1'b1;
            break;
          end
          if (mirror_key[idx] == k) begin
            r.hit = 1'b1;
            break;
          end
          idx = step_down(idx, k);
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        while (slot_taken(idx)) begin
          if (mirror_key[idx] == k) begin
            r.hit = 1'b1;
            break;
          end
          idx = step_down(idx, k);
        end
        if (r.hit && w.cmd == CMD_DELETE) begin
          r.changed = 1'b1;
          // pull up successor if there is a right subtree, else predecessor
          while (1'b1) begin
            if (slot_taken(2 * idx + 2)) begin
              pick = 2 * idx + 2;
              while (slot_taken(2 * pick + 1)) pick = 2 * pick + 1;
            end else if (slot_taken(2 * idx + 1)) begin
              pick = 2 * idx + 1;
              while (slot_taken(2 * pick + 2)) pick = 2 * pick + 2;
            end else begin
              mirror_used[idx] = 1'b0;
              break;
            end
            mirror_key[idx] = mirror_key[pick];
            idx = pick;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: ERROR %s", $time, what);
    fail_count++;
  endtask

  task automatic check_word(rsp_t got);
    rsp_t want;
    word_count++;
    if (flags_due.size() == 0) begin
      report_mismatch($sformatf("result word %0d arrived with nothing outstanding", word_count));
      return;
    end
    want = flags_due.pop_front();
    if (got.hit !== want.hit)
      report_mismatch($sformatf("word %0d hit %b, want %b", word_count, got.hit, want.hit));
    if (got.changed !== want.changed)
      report_mismatch($sformatf("word %0d changed %b, want %b", word_count,
                                got.changed, want.changed));
    if (got.out_of_room !== want.out_of_room)
      report_mismatch($sformatf("word %0d out_of_room %b, want %b", word_count,
                                got.out_of_room, want.out_of_room));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (mirror_used[i]) mirror_used[i] = 1'b0;
      mirror_limit = SLOTS_IN_USE_RST;
      flags_due.delete();
      words_pending <= 0;
    end else begin
      if (done === 1'b1) check_word(rsp);
      else if (done !== 1'b0) report_mismatch("done strobe is unknown");
      if (start && busy === 1'b0) flags_due.push_back(apply_table_op(req));
      if (cfg_valid && cfg_ready === 1'b1) mirror_limit = cfg_data;
      words_pending <= flags_due.size();
    end
  end

endmodule

FILE: dv/array_bst_key_table_unit_test.sv
// Testbench top for the key table: stimulus, register writes and verdict.
module array_bst_key_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abkt_pkg::*;

  // cmd value with no operation behind it; the block must answer all-zero flags
  localparam logic [CMD_W-1:0]  CMD_NOP     = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int WORDS_PER_SET = 235;
  localparam int POOL_DEPTH    = 64;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             done;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  int words_pending;
  int fail_count;
  int cycle_count = 0;

  // keys recently inserted; reused so searches and deletes actually hit
  logic signed [KEY_W-1:0] recent_keys [$];

  // slots_in_use per random set: full size, a tiny tree (hides most slots),
  // full again (hidden contents come back), a single root, nothing at all,
  // a mid size, one random value, and full size to finish
  int set_limit [8] = '{1023, 7, 1023, 1, 0, 63, 500, 1023};

  always #5 clk = ~clk;

  array_bst_key_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  array_bst_key_table_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .words_pending (words_pending),
    .fail_count    (fail_count)
  );

  // Hard stop: covers the clearing pass, worst-case delete chains and long gaps
  // with a wide margin.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command word and hold it until the block takes it (start high
  // while busy low). start is left high so a back-to-back word needs no toggle.
  task automatic issue_word(logic [CMD_W-1:0] op, logic signed [KEY_W-1:0] k);
    req_t word;
    word.cmd = op;
    word.key = k;
    start <= 1'b1;
    req   <= word;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == CMD_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > POOL_DEPTH) void'(recent_keys.pop_front());
    end
  endtask

  task automatic pause_sender(int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result word has come back.
  // The first edge lets the scoreboard count a word taken at this edge.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic write_limit(int v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // mostly back-to-back or short gaps, now and then a long one;
  // profile 0 gives a stretch with no gaps at all
  function automatic int pick_gap(int profile);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (profile == 0 || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CMD_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_INSERT;
    if (r < 70) return CMD_SEARCH;
    if (r < 96) return CMD_DELETE;
    return CMD_NOP;
  endfunction

  // keys: reuse of live keys, a narrow band around zero for collisions,
  // the two extremes, and full-range random values
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 70) return $urandom_range(0, 16) - 8;
    if (r < 73) return KEY_MIN;
    if (r < 76) return KEY_MAX;
    return $urandom();
  endfunction

  initial begin
    set_limit[6] = $urandom_range(2, 1022);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty table, extremes, duplicate, no-op, deletes ---
    issue_word(CMD_SEARCH, 0);               // lookup in an empty tree
    issue_word(CMD_DELETE, 5);               // delete miss on empty tree
    issue_word(CMD_INSERT, 0);
    issue_word(CMD_INSERT, KEY_MIN);         // most negative key is a normal key
    issue_word(CMD_INSERT, KEY_MAX);
    pause_sender(pick_gap(1));
    issue_word(CMD_INSERT, -1);
    issue_word(CMD_INSERT, 1);
    issue_word(CMD_INSERT, -32'sd2147483647);
    issue_word(CMD_INSERT, 0);               // duplicate: hit, no change
    issue_word(CMD_SEARCH, KEY_MIN);
    issue_word(CMD_SEARCH, KEY_MAX);
    issue_word(CMD_SEARCH, 12345);
    issue_word(CMD_NOP, 0);
    pause_sender(pick_gap(1));
    issue_word(CMD_DELETE, 0);               // root with both children
    issue_word(CMD_SEARCH, 0);
    issue_word(CMD_DELETE, KEY_MIN);
    issue_word(CMD_DELETE, 42);
    settle();

    // no usable slots: every insert overflows, lookups miss
    write_limit(0);
    issue_word(CMD_INSERT, 7);
    issue_word(CMD_SEARCH, 1);
    issue_word(CMD_DELETE, 1);
    settle();

    // only the root usable, then full size brings hidden slots back
    write_limit(1);
    issue_word(CMD_SEARCH, 1);
    issue_word(CMD_INSERT, 99);
    settle();
    write_limit(1023);
    issue_word(CMD_SEARCH, -1);

    // --- random sets, one slots_in_use value each ---
    foreach (set_limit[s]) begin
      settle();
      write_limit(set_limit[s]);
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        issue_word(pick_op(), pick_key());
        pause_sender(pick_gap(s % 3));
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
